[src/bda_pkg.sv]
// Shared types and constants for the buddy allocator.
// No dependencies.
package bda_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int LOG_W = 5;
    localparam int ENT_W = 6;
    localparam int ALLOC_BIT = 5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // table write port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [ENT_W-1:0] data;
    } bda_wr_t;

endpackage

[src/bda_table.sv]
// Block table: 1024 x 6 synchronous RAM, one write and one read port.
// Read data registered. Depends on bda_pkg.
module bda_table (
    input  logic                         aclk,
    input  bda_pkg::bda_wr_t             wr,
    input  logic [bda_pkg::IDX_W-1:0]    rd_addr,
    output logic [bda_pkg::ENT_W-1:0]    rd_data
);

    logic [bda_pkg::ENT_W-1:0] mem [bda_pkg::DEPTH];
    logic [bda_pkg::ENT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/buddy_allocator.sv]
// Buddy allocator top level: control sequencer around the block table RAM.
// Allocate: scan of the table, shift-right of the tail, then split writes; an oversize request
//   goes straight to the response. Free: write back as free, then merge scans, each merge
//   followed by a shift-left of the tail; a bad position goes straight to the response.
// Throughput: one operation at a time; the walk over the table RAM (one read per cycle) sets it.
// Reset: synchronous, active low; an init state writes the whole-pool block to entry 0,
//   then the block accepts transfers.
module buddy_allocator #(
    parameter int POOL_LOG2      = 20,
    parameter int MIN_BLOCK_LOG2 = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [20:0] s_request_size,
    input  logic [9:0]  s_block_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [19:0] m_block_offset,
    output logic [20:0] m_granted_size,
    output logic [20:0] m_allocated_total
);

    // offsets and totals reach 2^POOL_LOG2
    localparam int OW    = POOL_LOG2 + 1;
    localparam int CW    = bda_pkg::CNT_W;
    localparam int LW    = bda_pkg::LOG_W;
    localparam int EW    = bda_pkg::ENT_W;
    localparam int AB    = bda_pkg::ALLOC_BIT;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_ASCAN = 4'd3;
    localparam logic [3:0] ST_SHR   = 4'd4;
    localparam logic [3:0] ST_ANEW  = 4'd5;
    localparam logic [3:0] ST_FRD   = 4'd6;
    localparam logic [3:0] ST_FWAIT = 4'd7;
    localparam logic [3:0] ST_MSCAN = 4'd8;
    localparam logic [3:0] ST_MWR   = 4'd9;
    localparam logic [3:0] ST_SHL   = 4'd10;
    localparam logic [3:0] ST_RESP  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic          op_reg, op_next;
    logic [20:0]   req_reg, req_next;
    logic [9:0]    pos_reg, pos_next;
    logic [LW-1:0] tlog_reg, tlog_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [OW-1:0] tot_reg, tot_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          dv_reg, dv_next;
    logic [CW-1:0] dix_reg, dix_next;
    logic [OW-1:0] off_reg, off_next;
    logic          found_reg, found_next;
    logic [CW-1:0] best_reg, best_next;
    logic [LW-1:0] bests_reg, bests_next;
    logic [OW-1:0] bestoff_reg, bestoff_next;
    logic [CW-1:0] k_reg, k_next;
    logic [LW-1:0] lgf_reg, lgf_next;
    logic [CW-1:0] m_reg, m_next;
    logic [EW-1:0] prev_reg, prev_next;
    logic [OW-1:0] prevoff_reg, prevoff_next;
    logic          prevok_reg, prevok_next;
    logic          r_succ_reg, r_succ_next;
    logic [19:0]   r_off_reg, r_off_next;
    logic [20:0]   r_gsz_reg, r_gsz_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_succ_reg, m_succ_next;
    logic [19:0]   m_off_reg, m_off_next;
    logic [20:0]   m_gsz_reg, m_gsz_next;
    logic [20:0]   m_tot_reg, m_tot_next;

    bda_pkg::bda_wr_t             wr;
    logic [bda_pkg::IDX_W-1:0]    rd_addr;
    logic [EW-1:0]                rd_data;

    // combinational helpers
    logic [31:0]   need;
    logic [LW-1:0] tlog_c;
    logic [LW-1:0] cur_lg;
    logic [OW-1:0] cur_size;
    logic [OW:0]   align_mask;
    logic          issue;
    logic          hit;
    logic [CW-1:0] avail;
    logic [CW-1:0] diff;
    logic [CW-1:0] k_c;
    logic [31:0]   tot32;
    logic [31:0]   off32;
    logic [31:0]   gsz32;

    bda_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // request rounding and ceil-log2 of the rounded size
    always_comb begin
        need = {11'd0, req_reg};
        if (need < (32'd1 << MIN_BLOCK_LOG2)) begin
            need = 32'd1 << MIN_BLOCK_LOG2;
        end
        tlog_c = '0;
        for (int l = 31; l >= 0; l--) begin
            if ((33'd1 << l) >= {1'b0, need}) begin
                tlog_c = LW'(l);
            end
        end
    end

    assign cur_lg     = rd_data[LW-1:0];
    assign cur_size   = OW'(1) << cur_lg;
    assign align_mask = ((OW+1)'(2) << prev_reg[LW-1:0]) - (OW+1)'(1);
    assign hit = dv_reg && prevok_reg && !prev_reg[AB] && !rd_data[AB]
              && (prev_reg[LW-1:0] == cur_lg)
              && ((({1'b0, prevoff_reg}) & align_mask) == '0);
    assign avail = CW'(bda_pkg::DEPTH) - cnt_reg;
    assign diff  = CW'(bests_reg - tlog_reg);
    assign k_c   = (avail < diff) ? avail : diff;
    assign tot32 = 32'(tot_reg);
    assign off32 = 32'(bestoff_reg);
    assign gsz32 = 32'd1 << lgf_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        req_next     = req_reg;
        pos_next     = pos_reg;
        tlog_next    = tlog_reg;
        cnt_next     = cnt_reg;
        tot_next     = tot_reg;
        idx_next     = idx_reg;
        dv_next      = 1'b0;
        dix_next     = idx_reg;
        off_next     = off_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        bests_next   = bests_reg;
        bestoff_next = bestoff_reg;
        k_next       = k_reg;
        lgf_next     = lgf_reg;
        m_next       = m_reg;
        prev_next    = prev_reg;
        prevoff_next = prevoff_reg;
        prevok_next  = prevok_reg;
        r_succ_next  = r_succ_reg;
        r_off_next   = r_off_reg;
        r_gsz_next   = r_gsz_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_succ_next  = m_succ_reg;
        m_off_next   = m_off_reg;
        m_gsz_next   = m_gsz_reg;
        m_tot_next   = m_tot_reg;
        wr           = '0;
        rd_addr      = idx_reg[bda_pkg::IDX_W-1:0];
        issue        = 1'b0;

        case (state_reg)
            ST_INIT: begin
                wr.we      = 1'b1;
                wr.addr    = '0;
                wr.data    = EW'(POOL_LOG2);
                cnt_next   = CW'(1);
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    req_next   = s_request_size;
                    pos_next   = s_block_position;
                    state_next = (s_op == bda_pkg::OP_FREE) ? ST_FRD : ST_PREP;
                end
            end
            ST_PREP: begin
                if ({1'b0, need} > (33'd1 << POOL_LOG2)) begin
                    r_succ_next = 1'b0;
                    r_off_next  = '0;
                    r_gsz_next  = '0;
                    state_next  = ST_RESP;
                end else begin
                    tlog_next  = tlog_c;
                    idx_next   = '0;
                    off_next   = '0;
                    found_next = 1'b0;
                    bests_next = LW'(POOL_LOG2);
                    state_next = ST_ASCAN;
                end
            end
            ST_ASCAN: begin
                // smallest fitting free block, last one on ties
                issue = idx_reg < cnt_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                dv_next = issue;
                if (dv_reg) begin
                    if (!rd_data[AB] && cur_lg >= tlog_reg && cur_lg <= bests_reg) begin
                        found_next   = 1'b1;
                        best_next    = dix_reg;
                        bests_next   = cur_lg;
                        bestoff_next = off_reg;
                    end
                    off_next = off_reg + cur_size;
                end
                if (!issue && !dv_reg) begin
                    if (!found_reg) begin
                        r_succ_next = 1'b0;
                        r_off_next  = '0;
                        r_gsz_next  = '0;
                        state_next  = ST_RESP;
                    end else begin
                        k_next   = k_c;
                        lgf_next = bests_reg - k_c[LW-1:0];
                        m_next   = '0;
                        if (k_c != '0 && cnt_reg > best_reg + CW'(1)) begin
                            idx_next   = cnt_reg - CW'(1);
                            state_next = ST_SHR;
                        end else begin
                            state_next = ST_ANEW;
                        end
                    end
                end
            end
            ST_SHR: begin
                // move the tail up by k, top entry first
                issue = idx_reg > best_reg;
                if (issue) begin
                    idx_next = idx_reg - CW'(1);
                end
                dv_next = issue;
                if (dv_reg) begin
                    wr.we   = 1'b1;
                    wr.addr = bda_pkg::IDX_W'(dix_reg + k_reg);
                    wr.data = rd_data;
                end
                if (!issue && !dv_reg) begin
                    state_next = ST_ANEW;
                end
            end
            ST_ANEW: begin
                // granted block, then its split-off buddies in rising size
                wr.we   = 1'b1;
                wr.addr = bda_pkg::IDX_W'(best_reg + m_reg);
                if (m_reg == '0) begin
                    wr.data = {1'b1, lgf_reg};
                end else begin
                    wr.data = {1'b0, LW'(lgf_reg + m_reg[LW-1:0] - LW'(1))};
                end
                if (m_reg == k_reg) begin
                    cnt_next    = cnt_reg + k_reg;
                    tot_next    = tot_reg + (OW'(1) << lgf_reg);
                    r_succ_next = 1'b1;
                    r_off_next  = off32[19:0];
                    r_gsz_next  = gsz32[20:0];
                    state_next  = ST_RESP;
                end else begin
                    m_next = m_reg + CW'(1);
                end
            end
            ST_FRD: begin
                rd_addr = pos_reg;
                if ({1'b0, pos_reg} < cnt_reg) begin
                    state_next = ST_FWAIT;
                end else begin
                    r_succ_next = 1'b0;
                    r_off_next  = '0;
                    r_gsz_next  = '0;
                    state_next  = ST_RESP;
                end
            end
            ST_FWAIT: begin
                if (rd_data[AB]) begin
                    tot_next = tot_reg - cur_size;
                end
                wr.we       = 1'b1;
                wr.addr     = pos_reg;
                wr.data     = {1'b0, cur_lg};
                idx_next    = '0;
                off_next    = '0;
                prevok_next = 1'b0;
                state_next  = ST_MSCAN;
            end
            ST_MSCAN: begin
                // first mergeable aligned pair from the bottom
                issue = (idx_reg < cnt_reg) && !hit;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                dv_next = issue;
                if (hit) begin
                    best_next  = dix_reg - CW'(1);
                    state_next = ST_MWR;
                end else begin
                    if (dv_reg) begin
                        prev_next    = rd_data;
                        prevoff_next = off_reg;
                        prevok_next  = 1'b1;
                        off_next     = off_reg + cur_size;
                    end
                    if (!issue && !dv_reg) begin
                        r_succ_next = 1'b1;
                        r_off_next  = '0;
                        r_gsz_next  = '0;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_MWR: begin
                wr.we      = 1'b1;
                wr.addr    = best_reg[bda_pkg::IDX_W-1:0];
                wr.data    = {1'b0, LW'(prev_reg[LW-1:0] + LW'(1))};
                idx_next   = best_reg + CW'(2);
                state_next = ST_SHL;
            end
            ST_SHL: begin
                // close the gap left by the absorbed buddy
                issue = idx_reg < cnt_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                dv_next = issue;
                if (dv_reg) begin
                    wr.we   = 1'b1;
                    wr.addr = bda_pkg::IDX_W'(dix_reg - CW'(1));
                    wr.data = rd_data;
                end
                if (!issue && !dv_reg) begin
                    cnt_next    = cnt_reg - CW'(1);
                    idx_next    = '0;
                    off_next    = '0;
                    prevok_next = 1'b0;
                    state_next  = ST_MSCAN;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_succ_next  = r_succ_reg;
                    m_off_next   = r_off_reg;
                    m_gsz_next   = r_gsz_reg;
                    m_tot_next   = tot32[20:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= CW'(1);
            tot_reg     <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tot_reg     <= tot_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        req_reg     <= req_next;
        pos_reg     <= pos_next;
        tlog_reg    <= tlog_next;
        idx_reg     <= idx_next;
        dix_reg     <= dix_next;
        off_reg     <= off_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        bests_reg   <= bests_next;
        bestoff_reg <= bestoff_next;
        k_reg       <= k_next;
        lgf_reg     <= lgf_next;
        m_reg       <= m_next;
        prev_reg    <= prev_next;
        prevoff_reg <= prevoff_next;
        prevok_reg  <= prevok_next;
        r_succ_reg  <= r_succ_next;
        r_off_reg   <= r_off_next;
        r_gsz_reg   <= r_gsz_next;
        m_succ_reg  <= m_succ_next;
        m_off_reg   <= m_off_next;
        m_gsz_reg   <= m_gsz_next;
        m_tot_reg   <= m_tot_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_success         = m_succ_reg;
    assign m_block_offset    = m_off_reg;
    assign m_granted_size    = m_gsz_reg;
    assign m_allocated_total = m_tot_reg;

    // block count stays within the table
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) && (cnt_reg <= CW'(bda_pkg::DEPTH)))
        else $error("block count out of range");

    // allocated bytes never exceed the pool
    a_tot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tot_reg <= (OW'(1) << POOL_LOG2))
        else $error("allocated total exceeds pool");

    // a new result is loaded only from the response state
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == ST_RESP))
        else $error("result loaded outside response state");

    // a failed or free result never reports a granted size
    a_gsz: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && (!r_succ_reg || op_reg == bda_pkg::OP_FREE))
        |-> (r_gsz_reg == '0))
        else $error("granted size on non-allocation");

endmodule
